// File: rtl/rcd_pkg.sv
`default_nettype none
package rcd_pkg;

    // Fixed widths of the data words, primes, configuration words and index
    localparam int DATA_WIDTH  = 64;
    localparam int PRIME_WIDTH = 32;
    localparam int CFG_WIDTH   = 32;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME_P  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME_Q  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PUB_EXP  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CFG_WIDTH-1:0] RST_PRIME_P = 32'd137;
    localparam logic [CFG_WIDTH-1:0] RST_PRIME_Q = 32'd131;
    localparam logic [CFG_WIDTH-1:0] RST_PUB_EXP = 32'd3;

endpackage
`default_nettype wire

// File: rtl/rcd_div.sv
`default_nettype none
module rcd_div
    import rcd_pkg::*;
#(
    parameter int NUM_W = DATA_WIDTH,
    parameter int DEN_W = PRIME_WIDTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quo,
    output logic      [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] sh_reg, sh_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        trial = {rem_reg, sh_reg[NUM_W-1]};
        fits  = (trial >= {1'b0, den_reg});
    end

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            run_next = 1'b1;
            cnt_next = CNT_W'(NUM_W - 1);
            sh_next  = num;
            rem_next = '0;
            den_next = den;
        end else if (run_reg) begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            sh_next  = {sh_reg[NUM_W-2:0], fits};
            if (cnt_reg == '0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = sh_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

// File: rtl/rsa_crt_decrypt.sv
`default_nettype none
// RSA decryption by the Chinese remainder theorem.
// Configuration: write prime_p (index 0), prime_q (1) and public_exponent (2)
// through cfg_we/cfg_index/cfg_wdata while the block is idle; writes take
// effect at once. Reset loads p=137, q=131, e=3.
// Input: s_ciphertext with s_valid/s_ready. s_ready is high only while the
// sequencer is idle; one request is worked on at a time.
// Output: m_plaintext with m_valid/m_ready, held in an output register, so
// a new request is taken while the previous result waits for the receiver.
// A finished result waits in the sequencer until the output register frees.
// All divisions run through one bit-serial divider (one dividend bit per
// cycle) and all products through one registered multiplier. A request
// passes through three modular inversions by extended Euclid, the two
// exponentiations mod p and mod q, and the CRT recombination.
// Reset clears the sequencer and the output valid; no clearing pass.
module rsa_crt_decrypt
    import rcd_pkg::*;
#(
    parameter int PRIME_WIDTH = rcd_pkg::PRIME_WIDTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_WIDTH-1:0]  cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [DATA_WIDTH-1:0] s_ciphertext,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [DATA_WIDTH-1:0] m_plaintext
);

    localparam int W  = PRIME_WIDTH;
    localparam int MW = 2 * W + 2;
    localparam int SW = 5;

    localparam logic [SW-1:0] S_IDLE     = 5'd0;
    localparam logic [SW-1:0] S_INV_CHK  = 5'd1;
    localparam logic [SW-1:0] S_INV_QUOT = 5'd2;
    localparam logic [SW-1:0] S_INV_UPD  = 5'd3;
    localparam logic [SW-1:0] S_DIV_GO   = 5'd4;
    localparam logic [SW-1:0] S_DIV_WAIT = 5'd5;
    localparam logic [SW-1:0] S_POW_INIT = 5'd6;
    localparam logic [SW-1:0] S_POW_BASE = 5'd7;
    localparam logic [SW-1:0] S_POW_BIT  = 5'd8;
    localparam logic [SW-1:0] S_POW_AMUL = 5'd9;
    localparam logic [SW-1:0] S_POW_ACC  = 5'd10;
    localparam logic [SW-1:0] S_POW_SMUL = 5'd11;
    localparam logic [SW-1:0] S_POW_SQ   = 5'd12;
    localparam logic [SW-1:0] S_CRT_RED  = 5'd13;
    localparam logic [SW-1:0] S_CRT_DIFF = 5'd14;
    localparam logic [SW-1:0] S_CRT_HMUL = 5'd15;
    localparam logic [SW-1:0] S_CRT_HDIV = 5'd16;
    localparam logic [SW-1:0] S_CRT_H    = 5'd17;
    localparam logic [SW-1:0] S_CRT_HQ   = 5'd18;
    localparam logic [SW-1:0] S_CRT_OUT  = 5'd19;

    logic [W-1:0] p_reg, q_reg, e_reg;
    logic [W-1:0] pm1, qm1;

    logic [SW-1:0] state_reg, state_next, ret_reg, ret_next;
    logic [DATA_WIDTH-1:0] c_reg, c_next;
    logic [1:0]   isel_reg, isel_next;
    logic         psel_reg, psel_next;
    logic [W-1:0] ra_reg, ra_next, rb_reg, rb_next, binv_reg, binv_next;
    logic [W:0]   s0_reg, s0_next, s1_reg, s1_next;
    logic [W-1:0] qinv_reg, qinv_next, dp_reg, dp_next, dq_reg, dq_next;
    logic [W-1:0] mod_reg, mod_next, ex_reg, ex_next;
    logic [W-1:0] acc_reg, acc_next, b_reg, b_next;
    logic [W-1:0] m1_reg, m1_next, m2_reg, m2_next;
    logic [W-1:0] d_reg, d_next, h_reg, h_next;
    logic [DATA_WIDTH-1:0] num_reg, num_next;
    logic [W-1:0] den_reg, den_next;
    logic [MW-1:0] mul_reg;
    logic signed [W:0] ma, mb;
    logic signed [MW-1:0] mul_next;
    logic         ov_reg, ov_next;
    logic [DATA_WIDTH-1:0] out_reg, out_next;
    logic [W-1:0] inv_res, qred;
    logic [W:0]   dsum;

    logic                  div_done;
    logic [DATA_WIDTH-1:0] div_quo;
    logic [W-1:0]          div_rem;

    // Shared divider
    rcd_div #(
        .NUM_W (DATA_WIDTH),
        .DEN_W (W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_DIV_GO),
        .num     (num_reg),
        .den     (den_reg),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    assign pm1 = (p_reg == '0) ? '0 : p_reg - 1'b1;
    assign qm1 = (q_reg == '0) ? '0 : q_reg - 1'b1;

    // Lift a negative Bezout coefficient by the modulus
    assign inv_res = s0_reg[W] ? s0_reg[W-1:0] + binv_reg : s0_reg[W-1:0];
    // Reduce qinv by one conditional subtraction of p
    assign qred = (qinv_reg >= p_reg) ? qinv_reg - p_reg : qinv_reg;
    assign dsum = {1'b0, m1_reg} + {1'b0, p_reg} - {1'b0, div_rem};

    // Select multiplier operands
    always_comb begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            S_INV_QUOT: begin
                ma = $signed({1'b0, div_quo[W-1:0]});
                mb = $signed(s1_reg);
            end
            S_POW_BIT: begin
                ma = $signed({1'b0, ex_reg[0] ? acc_reg : b_reg});
                mb = $signed({1'b0, b_reg});
            end
            S_POW_ACC: begin
                ma = $signed({1'b0, b_reg});
                mb = $signed({1'b0, b_reg});
            end
            S_CRT_HMUL: begin
                ma = $signed({1'b0, qred});
                mb = $signed({1'b0, d_reg});
            end
            // Keep h*q in the product register while the result waits
            S_CRT_HQ, S_CRT_OUT: begin
                ma = $signed({1'b0, h_reg});
                mb = $signed({1'b0, q_reg});
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
        mul_next = MW'(ma * mb);
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        c_next     = c_reg;
        isel_next  = isel_reg;
        psel_next  = psel_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        binv_next  = binv_reg;
        s0_next    = s0_reg;
        s1_next    = s1_reg;
        qinv_next  = qinv_reg;
        dp_next    = dp_reg;
        dq_next    = dq_reg;
        mod_next   = mod_reg;
        ex_next    = ex_reg;
        acc_next   = acc_reg;
        b_next     = b_reg;
        m1_next    = m1_reg;
        m2_next    = m2_reg;
        d_next     = d_reg;
        h_next     = h_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        ov_next    = ov_reg;
        out_next   = out_reg;

        // Drop the output valid once taken
        if (m_ready) begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    c_next     = s_ciphertext;
                    isel_next  = 2'd0;
                    ra_next    = q_reg;
                    rb_next    = p_reg;
                    binv_next  = p_reg;
                    s0_next    = (W+1)'(1);
                    s1_next    = '0;
                    state_next = S_INV_CHK;
                end
            end
            S_INV_CHK: begin
                if (rb_reg == '0) begin
                    // Store the inverse and load the next one, or start the exponentiations after the third
                    s0_next = (W+1)'(1);
                    s1_next = '0;
                    ra_next = e_reg;
                    unique case (isel_reg)
                        2'd0: begin
                            qinv_next = inv_res;
                            rb_next   = pm1;
                            binv_next = pm1;
                            isel_next = 2'd1;
                        end
                        2'd1: begin
                            dp_next   = inv_res;
                            rb_next   = qm1;
                            binv_next = qm1;
                            isel_next = 2'd2;
                        end
                        default: begin
                            dq_next    = inv_res;
                            psel_next  = 1'b0;
                            state_next = S_POW_INIT;
                        end
                    endcase
                end else begin
                    num_next   = DATA_WIDTH'(ra_reg);
                    den_next   = rb_reg;
                    ret_next   = S_INV_QUOT;
                    state_next = S_DIV_GO;
                end
            end
            S_INV_QUOT: begin
                ra_next    = rb_reg;
                rb_next    = div_rem;
                state_next = S_INV_UPD;
            end
            S_INV_UPD: begin
                s0_next    = s1_reg;
                s1_next    = s0_reg - mul_reg[W:0];
                state_next = S_INV_CHK;
            end
            S_DIV_GO: begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    state_next = ret_reg;
                end
            end
            S_POW_INIT: begin
                mod_next = psel_reg ? q_reg : p_reg;
                ex_next  = psel_reg ? dq_reg : dp_reg;
                if ((psel_reg ? q_reg : p_reg) == '0) begin
                    acc_next   = '0;
                    ex_next    = '0;
                    state_next = S_POW_BIT;
                end else begin
                    acc_next   = ((psel_reg ? q_reg : p_reg) == W'(1)) ? '0 : W'(1);
                    num_next   = c_reg;
                    den_next   = psel_reg ? q_reg : p_reg;
                    ret_next   = S_POW_BASE;
                    state_next = S_DIV_GO;
                end
            end
            S_POW_BASE: begin
                b_next     = div_rem;
                state_next = S_POW_BIT;
            end
            S_POW_BIT: begin
                if (ex_reg == '0) begin
                    if (psel_reg) begin
                        m2_next    = acc_reg;
                        state_next = S_CRT_RED;
                    end else begin
                        m1_next    = acc_reg;
                        psel_next  = 1'b1;
                        state_next = S_POW_INIT;
                    end
                end else if (ex_reg[0]) begin
                    state_next = S_POW_AMUL;
                end else begin
                    state_next = S_POW_SMUL;
                end
            end
            S_POW_AMUL: begin
                num_next   = DATA_WIDTH'(mul_reg[2*W-1:0]);
                den_next   = mod_reg;
                ret_next   = S_POW_ACC;
                state_next = S_DIV_GO;
            end
            S_POW_ACC: begin
                acc_next   = div_rem;
                state_next = S_POW_SMUL;
            end
            S_POW_SMUL: begin
                num_next   = DATA_WIDTH'(mul_reg[2*W-1:0]);
                den_next   = mod_reg;
                ret_next   = S_POW_SQ;
                state_next = S_DIV_GO;
            end
            S_POW_SQ: begin
                b_next     = div_rem;
                ex_next    = ex_reg >> 1;
                state_next = S_POW_BIT;
            end
            S_CRT_RED: begin
                if (p_reg == '0) begin
                    h_next     = '0;
                    state_next = S_CRT_HQ;
                end else begin
                    num_next   = DATA_WIDTH'(m2_reg);
                    den_next   = p_reg;
                    ret_next   = S_CRT_DIFF;
                    state_next = S_DIV_GO;
                end
            end
            S_CRT_DIFF: begin
                d_next     = (dsum >= {1'b0, p_reg}) ? W'(dsum - {1'b0, p_reg})
                                                     : dsum[W-1:0];
                state_next = S_CRT_HMUL;
            end
            S_CRT_HMUL: begin
                state_next = S_CRT_HDIV;
            end
            S_CRT_HDIV: begin
                num_next   = DATA_WIDTH'(mul_reg[2*W-1:0]);
                den_next   = p_reg;
                ret_next   = S_CRT_H;
                state_next = S_DIV_GO;
            end
            S_CRT_H: begin
                h_next     = div_rem;
                state_next = S_CRT_HQ;
            end
            S_CRT_HQ: begin
                state_next = S_CRT_OUT;
            end
            S_CRT_OUT: begin
                // Hold until the output register is free
                if (!ov_reg || m_ready) begin
                    out_next   = DATA_WIDTH'(m2_reg) + DATA_WIDTH'(mul_reg[2*W-1:0]);
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg <= W'(RST_PRIME_P);
            q_reg <= W'(RST_PRIME_Q);
            e_reg <= W'(RST_PUB_EXP);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PRIME_P: p_reg <= W'(cfg_wdata);
                CFG_PRIME_Q: q_reg <= W'(cfg_wdata);
                CFG_PUB_EXP: e_reg <= W'(cfg_wdata);
                default:     p_reg <= p_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
        ret_reg  <= ret_next;
        c_reg    <= c_next;
        isel_reg <= isel_next;
        psel_reg <= psel_next;
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        binv_reg <= binv_next;
        s0_reg   <= s0_next;
        s1_reg   <= s1_next;
        qinv_reg <= qinv_next;
        dp_reg   <= dp_next;
        dq_reg   <= dq_next;
        mod_reg  <= mod_next;
        ex_reg   <= ex_next;
        acc_reg  <= acc_next;
        b_reg    <= b_next;
        m1_reg   <= m1_next;
        m2_reg   <= m2_next;
        d_reg    <= d_next;
        h_reg    <= h_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        mul_reg  <= mul_next;
        out_reg  <= out_next;
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = ov_reg;
    assign m_plaintext = out_reg;

endmodule
`default_nettype wire

// File: tb/rsa_crt_decrypt_tb.sv
`default_nettype none
module rsa_crt_decrypt_tb;
    import rcd_pkg::*;

    // Index with no register behind it; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_WIDTH-1:0]   cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [DATA_WIDTH-1:0]  s_ciphertext;
    logic                   m_valid;
    logic                   m_ready;
    logic [DATA_WIDTH-1:0]  m_plaintext;

    // Shadow copy of the key registers
    logic [63:0] key_p;
    logic [63:0] key_q;
    logic [63:0] key_e;

    logic [63:0] plaintext_due[$];
    int          errors;
    int          rx_hold;
    bit          no_idle;

    rsa_crt_decrypt u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_ciphertext (s_ciphertext),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_plaintext  (m_plaintext)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Extended Euclid inverse of a mod b, coefficients in two's complement
    function automatic logic [63:0] euclid_inv(logic [63:0] a, logic [63:0] b);
        logic [63:0] ra, rb, s0, s1, s, quot, rem;
        ra = a;
        rb = b;
        s0 = 64'd1;
        s1 = 64'd0;
        while (rb != 64'd0) begin
            quot = ra / rb;
            rem  = ra % rb;
            s    = s0 - quot * s1;
            ra   = rb;
            rb   = rem;
            s0   = s1;
            s1   = s;
        end
        if (s0[63])
            s0 = s0 + b;
        return s0;
    endfunction

    function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] ex,
                                            logic [63:0] md);
        logic [63:0] acc, b;
        if (md == 64'd0)
            return 64'd0;
        acc = 64'd1 % md;
        b   = base % md;
        while (ex != 64'd0) begin
            if (ex[0])
                acc = (acc * b) % md;
            b  = (b * b) % md;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    // Compute both CRT halves of the ciphertext and recombine them into the plaintext
    function automatic logic [63:0] crt_plaintext(logic [63:0] c);
        logic [63:0] pm1, qm1, qinv, dp, dq, m1, m2, h, diff;
        pm1  = (key_p == 64'd0) ? 64'd0 : key_p - 64'd1;
        qm1  = (key_q == 64'd0) ? 64'd0 : key_q - 64'd1;
        qinv = euclid_inv(key_q, key_p);
        dp   = euclid_inv(key_e, pm1);
        dq   = euclid_inv(key_e, qm1);
        m1   = pow_mod(c, dp, key_p);
        m2   = pow_mod(c, dq, key_q);
        h    = 64'd0;
        if (key_p != 64'd0) begin
            diff = (m1 + key_p - (m2 % key_p)) % key_p;
            h    = ((qinv % key_p) * diff) % key_p;
        end
        return m2 + h * key_q;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_PRIME_P: key_p = {32'd0, val};
            CFG_PRIME_Q: key_q = {32'd0, val};
            CFG_PUB_EXP: key_e = {32'd0, val};
            default: ;
        endcase
    endtask

    task automatic set_key(logic [31:0] p, logic [31:0] q, logic [31:0] e);
        write_reg(CFG_PRIME_P, p);
        write_reg(CFG_PRIME_Q, q);
        write_reg(CFG_PUB_EXP, e);
    endtask

    // Offer one request; valid drops only for a random gap before it
    task automatic send_ciphertext(logic [63:0] c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_ciphertext <= c;
        do @(posedge aclk); while (!s_ready);
        plaintext_due.push_back(crt_plaintext(c));
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (plaintext_due.size() != 0)
            @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_edge_words;
        send_ciphertext(64'd0);
        send_ciphertext(64'd1);
        send_ciphertext(64'hFFFF_FFFF_FFFF_FFFF);
        send_ciphertext(key_p);
        send_ciphertext(key_q);
        send_ciphertext(key_p * key_q);
        send_ciphertext(64'h8000_0000_0000_0000);
    endtask

    task automatic test_reset_key;
        send_edge_words();
        drain();
    endtask

    task automatic test_extreme_keys;
        set_key(32'd2, 32'd2, 32'd1);
        send_edge_words();
        drain();
        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_ciphertext(64'd0);
        send_ciphertext(64'hFFFF_FFFF_FFFF_FFFF);
        send_ciphertext(rand64());
        drain();
        // Real 32-bit primes with the usual exponent
        set_key(32'd4294967291, 32'd4294967279, 32'd65537);
        send_ciphertext(64'hFFFF_FFFF_FFFF_FFFF);
        send_ciphertext(rand64());
        drain();
        // Non-coprime key: shared factor, even exponent; stray index ignored
        set_key(32'd12, 32'd18, 32'd4);
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        send_ciphertext(rand64());
        send_ciphertext(64'd5);
        drain();
    endtask

    task automatic test_backpressure;
        set_key(32'd137, 32'd131, 32'd3);
        no_idle = 1'b1;
        rx_hold = 30000;
        repeat (5) send_ciphertext(rand64());
        no_idle = 1'b0;
        drain();
    endtask

    task automatic test_random;
        logic [31:0] p, q, e;
        for (int blk = 0; blk < 6; blk++) begin
            // Mostly narrow keys for speed, a few full-width ones
            if ($urandom_range(0, 3) == 0) begin
                p = $urandom | 32'h8000_0000;
                q = $urandom | 32'h8000_0000;
            end else begin
                p = $urandom_range(2, 65535);
                q = $urandom_range(2, 65535);
            end
            e = $urandom_range(0, 1) ? $urandom_range(1, 100) : ($urandom | 32'd1);
            set_key(p, q, e);
            no_idle = (blk == 2);
            repeat (20) send_ciphertext(rand64());
            no_idle = 1'b0;
            drain();
        end
    endtask

    // Receiver: random stall before each result, plus a long hold on request
    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold) @(posedge aclk);
                rx_hold = 0;
            end
            n = no_idle ? 0 : $urandom_range(0, 5);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compare each delivered plaintext with the oldest prediction
    always @(posedge aclk) begin
        logic [63:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (plaintext_due.size() == 0) begin
                $display("%0t: unexpected plaintext %h", $time, m_plaintext);
                errors++;
            end else begin
                want = plaintext_due.pop_front();
                if (m_plaintext !== want) begin
                    $display("%0t: plaintext mismatch expected %h actual %h",
                             $time, want, m_plaintext);
                    errors++;
                end
            end
        end
    end

    initial begin
        #200000000;
        $display("rsa_crt_decrypt verification failed");
        $finish;
    end

    initial begin
        errors       = 0;
        rx_hold      = 0;
        no_idle      = 1'b0;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_PRIME_P;
        cfg_wdata    = 32'd0;
        s_valid      = 1'b0;
        s_ciphertext = 64'd0;
        key_p        = {32'd0, RST_PRIME_P};
        key_q        = {32'd0, RST_PRIME_Q};
        key_e        = {32'd0, RST_PUB_EXP};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_key();
        test_extreme_keys();
        test_backpressure();
        test_random();
        if (errors == 0)
            $display("rsa_crt_decrypt verification clean");
        else
            $display("rsa_crt_decrypt verification failed");
        $finish;
    end

endmodule
`default_nettype wire
